FILE: design/ufs_pkg.sv
// ufs_pkg: shared types and constants of the union-find set engine
// used by ufs_engine and union_find_sets; no dependencies
package ufs_pkg;

    // element index fields on the stream are always this wide
    localparam int ELEM_W      = 10;
    localparam int ELEM_SPAN   = 1 << ELEM_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic {
        OP_UNION = 1'b0,
        OP_QUERY = 1'b1
    } ufs_op_t;

    typedef struct packed {
        ufs_op_t           op;
        logic [ELEM_W-1:0] elem_a;
        logic [ELEM_W-1:0] elem_b;
    } ufs_cmd_t;

    typedef struct packed {
        logic valid;
        logic same_set;
    } ufs_res_t;

endpackage

FILE: design/ufs_ram.sv
// ufs_ram: parent store, one write port and one registered read port
// no package dependencies; a same-cycle write to the read address is forwarded
module ufs_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/ufs_engine.sv
// ufs_engine: sequencer for clear, root walk, path compression and link
// depends on ufs_pkg and ufs_ram
module ufs_engine
    import ufs_pkg::*;
#(
    parameter int NUM_ELEMENTS = 1024,
    parameter int DEPTH        = 1024,
    parameter int AW           = 10
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  ufs_cmd_t cmd,
    output logic     cmd_ready,
    output ufs_res_t res,
    input  logic     res_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UP,
        S_DOWN,
        S_LINK,
        S_RESULT
    } state_t;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    state_t        state_reg, state_next;
    ufs_op_t       op_reg, op_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] root_reg, root_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic          which_reg, which_next;
    logic          same_reg, same_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_data;

    logic          fin;
    logic [AW-1:0] fin_root;
    logic          a_ok;
    logic          b_ok;

    ufs_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign a_ok      = (32'(cmd.elem_a) < NUM_ELEMENTS);
    assign b_ok      = (32'(cmd.elem_b) < NUM_ELEMENTS);
    assign cmd_ready = (state_reg == S_IDLE);
    assign res.valid    = (state_reg == S_RESULT);
    assign res.same_set = same_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        b_next     = b_reg;
        start_next = start_reg;
        cur_next   = cur_reg;
        root_next  = root_reg;
        ra_next    = ra_reg;
        which_next = which_reg;
        same_next  = same_reg;
        clr_next   = clr_reg;
        wr_en      = 1'b0;
        wr_addr    = cur_reg;
        wr_data    = root_reg;
        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        fin        = 1'b0;
        fin_root   = cur_reg;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next = cmd.op;
                    if (a_ok && b_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cmd.elem_a[AW-1:0];
                        cur_next   = cmd.elem_a[AW-1:0];
                        start_next = cmd.elem_a[AW-1:0];
                        b_next     = cmd.elem_b[AW-1:0];
                        which_next = 1'b0;
                        state_next = S_UP;
                    end
                    else if (cmd.op == OP_QUERY)
                    begin
                        // out-of-range elements are singletons
                        same_next  = (cmd.elem_a == cmd.elem_b);
                        state_next = S_RESULT;
                    end
                end
            end
            S_UP:
            begin
                if (rd_data == cur_reg)
                begin
                    if (start_reg == cur_reg)
                    begin
                        fin      = 1'b1;
                        fin_root = cur_reg;
                    end
                    else
                    begin
                        // root found, second walk from the start element
                        root_next  = cur_reg;
                        rd_en      = 1'b1;
                        rd_addr    = start_reg;
                        cur_next   = start_reg;
                        state_next = S_DOWN;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_data;
                    cur_next = rd_data;
                end
            end
            S_DOWN:
            begin
                // point the node at its root, follow its old parent
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = root_reg;
                if (rd_data == root_reg)
                begin
                    fin      = 1'b1;
                    fin_root = root_reg;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_data;
                    cur_next = rd_data;
                end
            end
            S_LINK:
            begin
                // smaller root becomes parent of the larger one
                wr_en = 1'b1;
                if (ra_reg < root_reg)
                begin
                    wr_addr = root_reg;
                    wr_data = ra_reg;
                end
                else
                begin
                    wr_addr = ra_reg;
                    wr_data = root_reg;
                end
                state_next = S_IDLE;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            root_next = fin_root;
            if (!which_reg)
            begin
                ra_next    = fin_root;
                which_next = 1'b1;
                rd_en      = 1'b1;
                rd_addr    = b_reg;
                cur_next   = b_reg;
                start_next = b_reg;
                state_next = S_UP;
            end
            else if (op_reg == OP_QUERY)
            begin
                same_next  = (ra_reg == fin_root);
                state_next = S_RESULT;
            end
            else
            begin
                state_next = S_LINK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            which_reg <= 1'b0;
            op_reg    <= OP_UNION;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            which_reg <= which_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg     <= b_next;
        start_reg <= start_next;
        cur_reg   <= cur_next;
        root_reg  <= root_next;
        ra_reg    <= ra_next;
        same_reg  <= same_next;
    end

    // a compressed node is never the root itself
    a_down_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN) |-> (cur_reg != root_reg))
        else $error("compression walk reached the root");

    // parents never lie above their child index
    a_parent_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UP) || (state_reg == S_DOWN)) |-> (rd_data <= cur_reg))
        else $error("parent index above child index");

    // a result waits unchanged until the output stage takes it
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res_ready) |=> (res.valid && $stable(res.same_set)))
        else $error("result dropped while output stage full");

endmodule

FILE: design/union_find_sets.sv
// union_find_sets: disjoint-set engine, stream ports and output register
// depends on ufs_pkg and ufs_engine (which holds ufs_ram)
//
// Disjoint-set engine over NUM_ELEMENTS elements, parent pointers kept in a
// single synchronous memory. Each input item carries an operation and two
// element indices: a union links the two roots (smaller root index becomes
// the parent), a query returns one item with same_set. Every root lookup
// compresses the path. After reset the block first writes every entry with
// its own index, one entry per cycle, and s_tready stays low meanwhile.
// Items are handled one at a time; the memory port does one read (and one
// write) per cycle. An item is accepted, the root of elem_a and then the
// root of elem_b is looked up (a walk up to the root, then a compression
// walk from the element when it is not the root itself), and the item ends
// in a result state for a query or a link state for a union. A query
// result waits while the output register is full and not drained. A query
// naming an element at or above NUM_ELEMENTS skips the memory; such a union
// is dropped in its accept cycle. A finished result waits in an output
// register while the next item is taken in.
module union_find_sets
    import ufs_pkg::*;
#(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // operation, elem_a, elem_b, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // same_set, zero pad
);

    // elements beyond the index field can never be named, so no storage
    localparam int DEPTH = (NUM_ELEMENTS < ELEM_SPAN) ? NUM_ELEMENTS : ELEM_SPAN;
    localparam int AW    = $clog2(DEPTH);

    ufs_cmd_t cmd;
    ufs_res_t res;
    logic     res_ready;
    logic     out_valid_reg, out_valid_next;
    logic     out_same_reg, out_same_next;

    // unpack the input item
    assign cmd.op     = ufs_op_t'(s_tdata[0]);
    assign cmd.elem_a = s_tdata[ELEM_W:1];
    assign cmd.elem_b = s_tdata[2*ELEM_W:ELEM_W+1];

    ufs_engine #(
        .NUM_ELEMENTS (NUM_ELEMENTS),
        .DEPTH        (DEPTH),
        .AW           (AW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register takes a result whenever it is empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_same_next  = out_same_reg;
        if (res_ready)
        begin
            out_valid_next = res.valid;
            if (res.valid)
            begin
                out_same_next = res.same_set;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_same_reg <= out_same_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, out_same_reg};

endmodule

FILE: tb/union_find_sets_check.sv
`timescale 1ns / 100ps
// union_find_sets_check: watches both stream channels of union_find_sets,
// keeps its own parent store and compares every same_set item; needs ufs_pkg
module union_find_sets_check
    import ufs_pkg::*;
#(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // operation, elem_a, elem_b, zero pad
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // same_set, zero pad
    output int                     fail_count,
    output int                     pending
);

    logic [ELEM_W-1:0] up_ptr [NUM_ELEMENTS];
    logic              same_set_q [$];

    // root lookup, then every node on the walked path points at the root
    function automatic logic [ELEM_W-1:0] find_rep(input logic [ELEM_W-1:0] e);
        logic [ELEM_W-1:0] r;
        logic [ELEM_W-1:0] cur;
        logic [ELEM_W-1:0] nxt;
        int                steps;
        r     = e;
        steps = 0;
        while (up_ptr[r] != r && steps < NUM_ELEMENTS)
        begin
            r = up_ptr[r];
            steps++;
        end
        cur   = e;
        steps = 0;
        while (cur != r && steps < NUM_ELEMENTS)
        begin
            nxt         = up_ptr[cur];
            up_ptr[cur] = r;
            cur         = nxt;
            steps++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ufs_op_t           op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [ELEM_W-1:0] ra;
        logic [ELEM_W-1:0] rb;
        logic              want;
        logic              in_range;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ELEMENTS; i++)
                up_ptr[i] = ELEM_W'(i);
            same_set_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // result side first: it always belongs to an earlier item
            if (m_tvalid && m_tready)
            begin
                if (same_set_q.size() == 0)
                begin
                    $error("same_set: no item expected, got %0b", m_tdata[0]);
                    fail_count++;
                end
                else
                begin
                    want = same_set_q.pop_front();
                    if (m_tdata[0] !== want)
                    begin
                        $error("same_set: expected %0b, got %0b", want, m_tdata[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                op       = ufs_op_t'(s_tdata[0]);
                a        = s_tdata[ELEM_W:1];
                b        = s_tdata[2*ELEM_W:ELEM_W+1];
                in_range = int'(a) < NUM_ELEMENTS && int'(b) < NUM_ELEMENTS;
                if (op == OP_UNION)
                begin
                    if (in_range)
                    begin
                        ra = find_rep(a);
                        rb = find_rep(b);
                        if (ra < rb)
                            up_ptr[rb] = ra;
                        else
                            up_ptr[ra] = rb;
                    end
                end
                else
                begin
                    if (in_range)
                    begin
                        ra   = find_rep(a);
                        rb   = find_rep(b);
                        want = (ra == rb);
                    end
                    else
                        want = (a == b);
                    same_set_q.push_back(want);
                end
            end
            pending = same_set_q.size();
        end
    end

endmodule

FILE: tb/union_find_sets_tb.sv
`timescale 1ns / 100ps
// union_find_sets_tb: stimulus and verdict for the union-find set engine
// needs ufs_pkg, union_find_sets and union_find_sets_check
module union_find_sets_tb;
    import ufs_pkg::*;

    localparam int NUM_ELEMENTS = 1024;
    // generous: clearing pass, slow stalls and gaps on every item, many times over
    localparam int unsigned LIMIT = 400000;
    // receiver hold-off long enough for the engine to back up into its input
    localparam int HOLD_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // operation, elem_a, elem_b, zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // same_set, zero pad

    int fail_count;
    int pending;

    // random gaps on both sides while set, none in the last stretch
    bit idle_on;
    // asks the receiver for one long hold-off
    bit hold_req;

    union_find_sets #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    union_find_sets_check #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit, counts from time zero so the clearing pass is included
    initial
    begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("union_find_sets_tb NOT OK");
        $finish;
    end

    // receiver: short random stalls, or one long hold-off on request
    initial
    begin : receiver
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one item; returns at the rising edge where it was taken
    task automatic send_item(input ufs_op_t op, input logic [ELEM_W-1:0] a,
                             input logic [ELEM_W-1:0] b);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({b, a, op});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // sender goes quiet until every same_set item has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem(input int lo, input int sz);
        return ELEM_W'(lo + $urandom_range(0, sz - 1));
    endfunction

    // random traffic: elements drawn from a roaming window so sets actually merge,
    // now and then a descending union chain that leaves a deep parent path
    task automatic random_batch(input int count, input int query_pct);
        int                sent;
        int                len;
        int                hi;
        int                win_lo;
        int                win_sz;
        ufs_op_t           op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        sent   = 0;
        win_sz = 16;
        win_lo = $urandom_range(0, ELEM_SPAN - win_sz);
        while (sent < count)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                win_sz = ($urandom_range(0, 5) == 0) ? ELEM_SPAN : $urandom_range(2, 48);
                win_lo = $urandom_range(0, ELEM_SPAN - win_sz);
            end
            if (query_pct < 100 && $urandom_range(0, 11) == 0)
            begin
                len = $urandom_range(3, 12);
                hi  = $urandom_range(len, ELEM_SPAN - 1);
                for (int i = 0; i < len; i++)
                    send_item(OP_UNION, ELEM_W'(hi - i), ELEM_W'(hi - i - 1));
                send_item(OP_QUERY, ELEM_W'(hi), ELEM_W'(hi - len));
                sent += len + 1;
            end
            else
            begin
                op = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_UNION;
                a  = pick_elem(win_lo, win_sz);
                b  = ($urandom_range(0, 15) == 0) ? a : pick_elem(win_lo, win_sz);
                send_item(op, a, b);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        s_tvalid = 1'b0;
        s_tdata  = '0;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // extremes of the index range on fresh singletons
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd1023);
        send_item(OP_QUERY, 10'd1023, 10'd1023);
        send_item(OP_UNION, 10'd1023, 10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd0);
        // same element twice
        send_item(OP_UNION, 10'd5, 10'd5);
        send_item(OP_QUERY, 10'd5, 10'd5);
        // alternating bit patterns
        send_item(OP_UNION, 10'd682, 10'd341);
        send_item(OP_QUERY, 10'd341, 10'd682);
        send_item(OP_UNION, 10'd341, 10'd1);
        // descending chain 908 -> 907 -> ... -> 900, deepest walk so far
        for (int i = 0; i < 8; i++)
            send_item(OP_UNION, ELEM_W'(908 - i), ELEM_W'(907 - i));
        send_item(OP_QUERY, 10'd908, 10'd900);
        send_item(OP_QUERY, 10'd908, 10'd899);
        // hang the chain under root 0, then walk it through the compressed path
        send_item(OP_UNION, 10'd900, 10'd1023);
        send_item(OP_QUERY, 10'd908, 10'd1023);
        // roots already equal: only compression happens
        send_item(OP_UNION, 10'd908, 10'd0);
        send_item(OP_QUERY, 10'd907, 10'd0);

        random_batch(400, 50);

        // long receiver hold while queries keep coming: output register fills,
        // engine stalls its input
        hold_req = 1'b1;
        random_batch(40, 90);
        drain_results();

        random_batch(500, 50);

        // last stretch at full rate on both sides
        idle_on = 1'b0;
        random_batch(340, 50);

        drain_results();
        repeat (30) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("union_find_sets_tb OK");
        else
            $display("union_find_sets_tb NOT OK");
        $finish;
    end

endmodule

FILE: union_find_sets.f
design/ufs_pkg.sv
design/ufs_ram.sv
design/ufs_engine.sv
design/union_find_sets.sv
tb/union_find_sets_check.sv
tb/union_find_sets_tb.sv
